FILE: hdl/tccw_pkg.sv
package tccw_pkg;

   localparam int unsigned DEF_COLUMNS = 80;
   localparam int unsigned DEF_ROWS    = 25;

   localparam logic [1:0] MODE_PUT  = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_MOVE = 2'd2;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_BLANK     = 8'd0;

   localparam logic CSR_FG_COLOR = 1'b0;
   localparam logic CSR_BG_COLOR = 1'b1;

   localparam logic [3:0] FG_RESET = 4'd15;
   localparam logic [3:0] BG_RESET = 4'd0;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  char_code;
      logic [10:0] read_index;
      logic [7:0]  new_row;
      logic [7:0]  new_col;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_word;
      logic [4:0]  pos_row;
      logic [6:0]  pos_col;
      logic        screen_cleared;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [15:0] fill_word;
   } clear_cmd_type;

   typedef struct packed {
      logic        wr_en;
      logic [15:0] word;
      logic        cleared;
   } step_type;

   function automatic logic [15:0] make_cell(input logic [3:0] bg, input logic [3:0] fg,
                                             input logic [7:0] ch);
      make_cell = {bg, fg, ch};
   endfunction

endpackage

FILE: hdl/tccw_cell_store.sv
module tccw_cell_store #(
   parameter int unsigned DEPTH  = 2000,
   parameter int unsigned ADDR_W = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [15:0]                    wr_data,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [15:0]                    rd_data,
   input  tccw_pkg::clear_cmd_type        clear_cmd,
   output logic                           busy
);
   import tccw_pkg::*;

   logic [15:0]       mem [DEPTH];
   logic [15:0]       rd_data_ff;
   logic              busy_ff;
   logic [ADDR_W-1:0] sweep_addr_ff;
   logic [15:0]       fill_ff;

   // sweep owns the write port while it runs
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[sweep_addr_ff] <= fill_ff;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         sweep_addr_ff <= '0;
         fill_ff       <= '0;
      end else if (clear_cmd.start) begin
         busy_ff       <= 1'b1;
         sweep_addr_ff <= '0;
         fill_ff       <= clear_cmd.fill_word;
      end else if (busy_ff) begin
         if (sweep_addr_ff == ADDR_W'(DEPTH - 1)) begin
            busy_ff <= 1'b0;
         end
         sweep_addr_ff <= sweep_addr_ff + 1'b1;
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

FILE: hdl/tccw_cursor.sv
module tccw_cursor #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25,
   parameter int unsigned ROW_W   = 5,
   parameter int unsigned COL_W   = 7,
   parameter int unsigned ADDR_W  = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  tccw_pkg::req_type      req,
   input  logic [3:0]             fg_color,
   input  logic [3:0]             bg_color,
   output logic [ROW_W-1:0]       row_cur,
   output logic [COL_W-1:0]       col_cur,
   output logic [ROW_W-1:0]       row_next,
   output logic [COL_W-1:0]       col_next,
   output logic [ADDR_W-1:0]      wr_addr,
   output tccw_pkg::step_type     step
);
   import tccw_pkg::*;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W:0]   row_tmp;
   logic [ROW_W:0]   row_inc;
   logic [COL_W:0]   col_inc;
   logic [COL_W-1:0] col_sel;
   logic [31:0]      addr_full;

   assign row_inc = (ROW_W + 1)'(row_ff) + 1'b1;
   assign col_inc = (COL_W + 1)'(col_ff) + 1'b1;

   always_comb begin
      row_tmp      = (ROW_W + 1)'(row_ff);
      col_in       = col_ff;
      col_sel      = col_ff;
      step.wr_en   = 1'b0;
      step.word    = '0;
      step.cleared = 1'b0;
      case (req.mode)
         MODE_PUT: begin
            if (req.char_code == CH_NEWLINE) begin
               row_tmp = row_inc;
               col_in  = '0;
            end else if (req.char_code == CH_BACKSPACE) begin
               if (col_ff != '0) begin
                  col_in     = col_ff - 1'b1;
                  col_sel    = col_ff - 1'b1;
                  step.wr_en = 1'b1;
                  step.word  = make_cell(bg_color, fg_color, CH_BLANK);
               end else if (row_ff != '0) begin
                  // back to the end of the row above, nothing erased
                  row_tmp = (ROW_W + 1)'(row_ff) - 1'b1;
                  col_in  = COL_W'(COLUMNS - 1);
               end
            end else begin
               step.wr_en = 1'b1;
               step.word  = make_cell(bg_color, fg_color, req.char_code);
               if (32'(col_inc) >= COLUMNS) begin
                  col_in  = '0;
                  row_tmp = row_inc;
               end else begin
                  col_in = col_inc[COL_W-1:0];
               end
            end
            if (32'(row_tmp) >= ROWS) begin
               row_tmp      = '0;
               step.cleared = 1'b1;
            end
         end
         MODE_MOVE: begin
            row_tmp = (32'(req.new_row) > ROWS - 1) ? (ROW_W + 1)'(ROWS - 1)
                                                    : (ROW_W + 1)'(req.new_row);
            col_in  = (32'(req.new_col) > COLUMNS - 1) ? COL_W'(COLUMNS - 1)
                                                       : COL_W'(req.new_col);
         end
         default: begin
         end
      endcase
      row_in = row_tmp[ROW_W-1:0];
   end

   assign addr_full = 32'(row_ff) * 32'(COLUMNS) + 32'(col_sel);
   assign wr_addr   = addr_full[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (step_en) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign row_cur  = row_ff;
   assign col_cur  = col_ff;
   assign row_next = row_in;
   assign col_next = col_in;

endmodule

FILE: hdl/text_console_cursor_writer_top.sv
// put, move, unused-mode items: result registered at acceptance, one item per cycle unless stalled
// read items: store data is registered, then the result in ST_READ; no item is taken in ST_READ
// a put that passes the bottom row blanks the store in the current colors; no item is taken meanwhile
// reset is synchronous; after it a clearing pass zeroes the store
// and no item is accepted until it ends; colors return to white on black, cursor to origin
module text_console_cursor_writer_top #(
   parameter int unsigned COLUMNS = tccw_pkg::DEF_COLUMNS,
   parameter int unsigned ROWS    = tccw_pkg::DEF_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tccw_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tccw_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [3:0]        csr_wdata
);
   import tccw_pkg::*;

   localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
   localparam int unsigned ROW_W      = $clog2(ROWS);
   localparam int unsigned COL_W      = $clog2(COLUMNS);
   localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type        state_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_item_ff;
   logic             rd_ok_ff;
   logic [3:0]       fg_ff, bg_ff;

   logic             accept;
   logic             rsp_taken;
   logic             store_busy;
   logic             in_range;
   logic             rd_en;
   logic [31:0]      ridx_ext;
   logic [15:0]      rd_data;
   logic [ROW_W-1:0] row_cur, row_next;
   logic [COL_W-1:0] col_cur, col_next;
   logic [31:0]      row_cur_ext, row_next_ext, col_cur_ext, col_next_ext;
   logic [ADDR_W-1:0] wr_addr;
   step_type         step;
   clear_cmd_type    clear_cmd;

   assign req_stall = (state_ff != ST_IDLE) || store_busy || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_taken = rsp_valid_ff && !rsp_stall;

   assign ridx_ext = 32'(req_item.read_index);
   assign in_range = ridx_ext < CELL_COUNT;
   assign rd_en    = accept && (req_item.mode == MODE_READ) && in_range;

   assign clear_cmd.start     = accept && step.cleared;
   assign clear_cmd.fill_word = make_cell(bg_ff, fg_ff, CH_BLANK);

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_FG_COLOR) begin
            fg_ff <= csr_wdata;
         end else begin
            bg_ff <= csr_wdata;
         end
      end
   end

   tccw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .ROW_W   (ROW_W),
      .COL_W   (COL_W),
      .ADDR_W  (ADDR_W)
   ) u_cursor (
      .clock    (clock),
      .reset    (reset),
      .step_en  (accept),
      .req      (req_item),
      .fg_color (fg_ff),
      .bg_color (bg_ff),
      .row_cur  (row_cur),
      .col_cur  (col_cur),
      .row_next (row_next),
      .col_next (col_next),
      .wr_addr  (wr_addr),
      .step     (step)
   );

   tccw_cell_store #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept && step.wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (step.word),
      .rd_en     (rd_en),
      .rd_addr   (ridx_ext[ADDR_W-1:0]),
      .rd_data   (rd_data),
      .clear_cmd (clear_cmd),
      .busy      (store_busy)
   );

   assign row_cur_ext  = 32'(row_cur);
   assign row_next_ext = 32'(row_next);
   assign col_cur_ext  = 32'(col_cur);
   assign col_next_ext = 32'(col_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_item.mode == MODE_READ)) begin
                  // the result slot is empty or being taken this cycle
                  state_ff     <= ST_READ;
                  rd_ok_ff     <= in_range;
                  rsp_valid_ff <= 1'b0;
               end else if (accept) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_item_ff.cell_word       <= step.word;
                  rsp_item_ff.pos_row         <= row_next_ext[4:0];
                  rsp_item_ff.pos_col         <= col_next_ext[6:0];
                  rsp_item_ff.screen_cleared  <= step.cleared;
               end else if (rsp_taken) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_READ: begin
               // the store read issued at acceptance has its data out in this state
               rsp_valid_ff               <= 1'b1;
               rsp_item_ff.cell_word      <= rd_ok_ff ? rd_data : 16'd0;
               rsp_item_ff.pos_row        <= row_cur_ext[4:0];
               rsp_item_ff.pos_col        <= col_cur_ext[6:0];
               rsp_item_ff.screen_cleared <= 1'b0;
               state_ff                   <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
               if (rsp_taken) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !accept)
      else $error("item accepted during store clear");

   a_read_enters_wait: assert property (@(posedge clock) disable iff (reset)
      accept && (req_item.mode == MODE_READ) |=> (state_ff == ST_READ) && !rsp_valid_ff)
      else $error("read item did not wait for store data");

   a_read_wait_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("read result not delivered after one cycle");

   a_wrap_starts_clear: assert property (@(posedge clock) disable iff (reset)
      accept && step.cleared |=> store_busy && rsp_valid_ff && rsp_item_ff.screen_cleared)
      else $error("bottom-row wrap did not start store clear");

endmodule

FILE: tb/tb_text_console_cursor_writer_top.sv
`timescale 1ns / 100ps

class console_scoreboard;
   localparam int COLS  = tccw_pkg::DEF_COLUMNS;
   localparam int ROWS  = tccw_pkg::DEF_ROWS;
   localparam int CELLS = COLS * ROWS;

   logic [15:0] screen [CELLS];
   int row;
   int col;
   logic [3:0] fg;
   logic [3:0] bg;
   tccw_pkg::rsp_type awaited_replies [$];
   int errors;

   function new();
      foreach (screen[i]) screen[i] = '0;
      row = 0;
      col = 0;
      fg = tccw_pkg::FG_RESET;
      bg = tccw_pkg::BG_RESET;
      errors = 0;
   endfunction

   function int pending();
      return awaited_replies.size();
   endfunction

   // advance the console copy by one accepted item and queue its reply
   function void note_request(tccw_pkg::req_type r);
      tccw_pkg::rsp_type e;
      e = '0;
      case (r.mode)
         tccw_pkg::MODE_PUT: begin
            if (r.char_code == tccw_pkg::CH_NEWLINE) begin
               row++;
               col = 0;
            end else if (r.char_code == tccw_pkg::CH_BACKSPACE) begin
               if (col != 0) begin
                  col--;
                  e.cell_word = {bg, fg, tccw_pkg::CH_BLANK};
                  screen[row * COLS + col] = e.cell_word;
               end else if (row != 0) begin
                  // column 0 steps to the end of the row above, nothing erased
                  row--;
                  col = COLS - 1;
               end
            end else begin
               e.cell_word = {bg, fg, r.char_code};
               screen[row * COLS + col] = e.cell_word;
               col++;
               if (col >= COLS) begin
                  col = 0;
                  row++;
               end
            end
            // past the bottom row: home the row and blank the screen
            if (row >= ROWS) begin
               row = 0;
               foreach (screen[i]) screen[i] = {bg, fg, tccw_pkg::CH_BLANK};
               e.screen_cleared = 1'b1;
            end
         end
         tccw_pkg::MODE_READ: begin
            if (r.read_index < CELLS) e.cell_word = screen[r.read_index];
         end
         tccw_pkg::MODE_MOVE: begin
            row = (r.new_row > ROWS - 1) ? ROWS - 1 : r.new_row;
            col = (r.new_col > COLS - 1) ? COLS - 1 : r.new_col;
         end
         default: ;
      endcase
      e.pos_row = 5'(row);
      e.pos_col = 7'(col);
      awaited_replies.push_back(e);
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 50) $display("%0t mismatch: %s", $time, msg);
   endtask

   task check_response(tccw_pkg::rsp_type got);
      tccw_pkg::rsp_type e;
      if (awaited_replies.size() == 0) begin
         report($sformatf("unexpected result %h", got));
      end else begin
         e = awaited_replies.pop_front();
         if (got.cell_word !== e.cell_word)
            report($sformatf("cell_word got %h exp %h", got.cell_word, e.cell_word));
         if (got.pos_row !== e.pos_row)
            report($sformatf("pos_row got %0d exp %0d", got.pos_row, e.pos_row));
         if (got.pos_col !== e.pos_col)
            report($sformatf("pos_col got %0d exp %0d", got.pos_col, e.pos_col));
         if (got.screen_cleared !== e.screen_cleared)
            report($sformatf("screen_cleared got %b exp %b",
                             got.screen_cleared, e.screen_cleared));
      end
   endtask
endclass

module tb_text_console_cursor_writer_top;
   localparam int COLS  = tccw_pkg::DEF_COLUMNS;
   localparam int ROWS  = tccw_pkg::DEF_ROWS;
   localparam int CELLS = COLS * ROWS;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tccw_pkg::req_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tccw_pkg::rsp_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic csr_index = tccw_pkg::CSR_FG_COLOR;
   logic [3:0] csr_wdata = '0;

   console_scoreboard sb;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   text_console_cursor_writer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #50_000_000;
      $display("tb_text_console_cursor_writer_top failed");
      $finish;
   end

   // result side: check accepted results, stall at random or for a long hold
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_item);
         if (hold_request) begin
            hold_left = 150;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 20);
         end
      end
   end

   function automatic tccw_pkg::req_type random_fill();
      tccw_pkg::req_type r;
      r.mode       = 2'($urandom_range(0, 3));
      r.char_code  = 8'($urandom_range(0, 255));
      r.read_index = 11'($urandom_range(0, 2047));
      r.new_row    = 8'($urandom_range(0, 255));
      r.new_col    = 8'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic offer(input tccw_pkg::req_type r);
      req_valid <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      if (!quiet && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic put_char(input logic [7:0] ch);
      tccw_pkg::req_type r;
      r = random_fill();
      r.mode = tccw_pkg::MODE_PUT;
      r.char_code = ch;
      offer(r);
   endtask

   task automatic read_cell(input int idx);
      tccw_pkg::req_type r;
      r = random_fill();
      r.mode = tccw_pkg::MODE_READ;
      r.read_index = 11'(idx);
      offer(r);
   endtask

   task automatic move_to(input int rw, input int cl);
      tccw_pkg::req_type r;
      r = random_fill();
      r.mode = tccw_pkg::MODE_MOVE;
      r.new_row = 8'(rw);
      r.new_col = 8'(cl);
      offer(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // a clear may still be sweeping the store after its result is out
   task automatic settle();
      repeat (CELLS + 16) @(posedge clock);
   endtask

   task automatic set_colors(input logic [3:0] f, input logic [3:0] b);
      csr_wr_en <= 1'b1;
      csr_index <= tccw_pkg::CSR_FG_COLOR;
      csr_wdata <= f;
      @(posedge clock);
      csr_index <= tccw_pkg::CSR_BG_COLOR;
      csr_wdata <= b;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.fg = f;
      sb.bg = b;
   endtask

   task automatic type_burst(input int n, input bit with_hold, input bit with_pause);
      int done;
      int pick;
      int sub;
      int idx;
      tccw_pkg::req_type r;
      done = 0;
      while (done < n) begin
         if (with_hold && done == n / 4) hold_request = 1'b1;
         if (with_pause && done == n / 2) drain();
         pick = $urandom_range(0, 99);
         sub = $urandom_range(0, 99);
         if (pick < 48) begin
            if (sub < 9) put_char(tccw_pkg::CH_NEWLINE);
            else if (sub < 16) put_char(tccw_pkg::CH_BACKSPACE);
            else put_char(8'($urandom_range(0, 255)));
            done++;
         end else if (pick < 70) begin
            // mostly cells just behind the cursor, which were likely written
            if (sub < 65) begin
               idx = sb.row * COLS + sb.col - $urandom_range(0, 8);
               if (idx < 0) idx = 0;
            end else if (sub < 90) begin
               idx = $urandom_range(0, CELLS - 1);
            end else begin
               idx = $urandom_range(0, 2047);
            end
            read_cell(idx);
            done++;
         end else if (pick < 88) begin
            if (sub < 75) move_to($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
            else move_to($urandom_range(0, 255), $urandom_range(0, 255));
            done++;
         end else if (pick < 94) begin
            // near the bottom right, so that typing soon clears the screen
            move_to(ROWS - 1, $urandom_range(COLS - 12, COLS - 1));
            done++;
         end else begin
            r = random_fill();
            r.mode = MODE_UNUSED;
            offer(r);
         end
      end
   endtask

   initial begin
      tccw_pkg::req_type r;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      settle();

      // directed part, reset colors
      read_cell(0);
      read_cell(CELLS - 1);
      read_cell(CELLS);
      read_cell(2047);
      put_char(tccw_pkg::CH_BACKSPACE);
      put_char(8'h41);
      put_char(8'hFF);
      put_char(tccw_pkg::CH_BLANK);
      read_cell(0);
      read_cell(1);
      put_char(tccw_pkg::CH_BACKSPACE);
      read_cell(2);
      put_char(tccw_pkg::CH_NEWLINE);
      put_char(tccw_pkg::CH_BACKSPACE);
      put_char(8'h5A);
      read_cell(COLS - 1);
      move_to(255, 255);
      move_to(0, 0);
      r = random_fill();
      r.mode = MODE_UNUSED;
      offer(r);
      move_to(ROWS - 1, COLS - 1);
      put_char(8'h78);
      read_cell(CELLS - 1);
      move_to(ROWS - 1, 5);
      put_char(tccw_pkg::CH_NEWLINE);
      read_cell(0);

      drain();
      settle();
      set_colors(4'd0, 4'd0);
      type_burst(110, 1'b0, 1'b0);

      drain();
      settle();
      set_colors(4'd15, 4'd15);
      type_burst(110, 1'b1, 1'b0);

      drain();
      settle();
      quiet = 1'b1;
      set_colors(4'd0, 4'd15);
      type_burst(110, 1'b0, 1'b1);

      drain();
      settle();
      quiet = 1'b0;
      set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      type_burst(110, 1'b0, 1'b0);

      drain();
      settle();
      set_colors(4'd15, 4'd0);
      type_burst(110, 1'b0, 1'b0);

      drain();
      settle();
      set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      type_burst(100, 1'b0, 1'b0);

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_text_console_cursor_writer_top passed");
      end else begin
         $display("tb_text_console_cursor_writer_top failed");
      end
      $finish;
   end
endmodule
